### rtl/core/h264_rtp_packetizer_unit_defines.svh
// Assertion macros shared by the RTP packetizer RTL.
// Included by the datapath; depends on nothing.
`ifndef H264_RTP_PACKETIZER_UNIT_DEFINES_SVH
`define H264_RTP_PACKETIZER_UNIT_DEFINES_SVH
// Checks that a condition implies a consequence on the same edge.
`define RTP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtp check failed");
// Checks that a condition implies a consequence on the next edge.
`define RTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtp check failed");
`endif

### rtl/core/hrtp_pkg.sv
// Package for the RTP packetizer: state codes, modes and command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hrtp_pkg;
	localparam int RtpHdrBytes = 12;
	localparam logic [7:0] TypeMask = 8'h1f;
	localparam logic [7:0] NriMask = 8'h60;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STORE = 2'd1,
		MODE_SINGLE = 2'd2,
		MODE_FU = 2'd3
	} mode_t;

	// Byte sources for the output mux.
	typedef enum logic [3:0] {
		SRC_RTP_HDR,
		SRC_STAP_IND,
		SRC_SPS_LEN_HI,
		SRC_SPS_LEN_LO,
		SRC_SPS_DATA,
		SRC_PPS_LEN_HI,
		SRC_PPS_LEN_LO,
		SRC_PPS_DATA,
		SRC_FU_IND,
		SRC_FU_HDR,
		SRC_NAL
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STAP_HDR,
		ST_STAP_IND,
		ST_SPS_HI,
		ST_SPS_LO,
		ST_SPS_DATA,
		ST_PPS_HI,
		ST_PPS_LO,
		ST_PPS_DATA,
		ST_SNG_HDR,
		ST_FU_HDR,
		ST_FU_IND,
		ST_FU_FHDR,
		ST_NAL
	} state_t;

	typedef struct packed {
		logic take;      // consume the held input request
		logic load;      // capture input request into hold register
		logic emit;      // present a byte on the output register
		src_t src;
		logic first;
		logic last;
		logic seq_inc;
		logic cnt_clr;
		logic cnt_inc;
		logic proc;      // apply the per-byte state update of the held request
	} cmd_t;

	typedef struct packed {
		logic hold_v;
		logic out_free;
		logic h_first;
		logic is_pset;
		logic pset_ok;
		logic stap_ok;
		logic fits;
		logic len_one;
		mode_t mode;
		logic beyond;
		logic need_fu_hdr;
		logic nal_last;
		logic [4:0] cnt;
		logic sps_end;
		logic pps_end;
		logic pps_zero;
	} sts_t;
endpackage
`default_nettype wire

### rtl/core/hrtp_datapath.sv
// Datapath of the RTP packetizer: input hold, unit state, parameter set
// stores and the output register. Uses hrtp_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "h264_rtp_packetizer_unit_defines.svh"
module hrtp_datapath #(
	parameter int SetMax = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [31:0] cfg_data,
	input wire logic [7:0] nal_byte,
	input wire logic nal_first,
	input wire logic [15:0] nal_length,
	input wire logic [31:0] frame_time_ms,
	input wire logic out_stall,
	input wire hrtp_pkg::cmd_t cmd,
	output hrtp_pkg::sts_t sts,
	output logic out_valid,
	output logic [7:0] packet_byte,
	output logic packet_first,
	output logic packet_last
);
	localparam int CW = $clog2(SetMax + 1);
	localparam int AW = $clog2(SetMax);

	logic [12:0] maxp_q;
	logic [6:0] ptype_q;
	logic [31:0] ssrc_q, tbase_q;
	logic [15:0] seq_q;
	logic [7:0] sps_mem [SetMax];
	logic [7:0] pps_mem [SetMax];
	logic [CW-1:0] sps_cnt_q, pps_cnt_q;
	logic [15:0] pos_q;
	logic [11:0] fill_q;
	hrtp_pkg::mode_t mode_q;
	logic [7:0] hdr_q;
	logic [31:0] ts_q;
	logic hv_q;
	logic [7:0] hb_q;
	logic hf_q;
	logic [15:0] hl_q;
	logic [31:0] hms_q;
	logic [4:0] cnt_q;
	logic ov_q;

	logic [12:0] maxp;
	logic [11:0] frag;
	logic [15:0] len;
	logic [4:0] htype;
	logic [15:0] pos1;
	logic [11:0] fill1;
	logic [31:0] ts_mul;
	logic [7:0] obyte;
	logic [AW-1:0] ci;

	always_comb begin
		maxp = maxp_q;
		if (maxp_q < 13'd64) maxp = 13'd64;
		if (maxp_q > 13'd4096) maxp = 13'd4096;
		frag = 12'(maxp - 13'd14);
		len = (hl_q == 16'd0) ? 16'd1 : hl_q;
		htype = hb_q[4:0];
		pos1 = pos_q + 16'd1;
		fill1 = fill_q + 12'd1;
		ts_mul = tbase_q + 32'(hms_q * 32'd90);
		ci = cnt_q[AW-1:0];
	end

	always_comb begin
		sts.hold_v = hv_q;
		sts.out_free = !ov_q || !out_stall;
		sts.h_first = hf_q;
		sts.is_pset = (htype == 5'd7) || (htype == 5'd8);
		sts.pset_ok = len <= 16'(SetMax);
		sts.stap_ok = (htype == 5'd5) && (sps_cnt_q != '0) && (pps_cnt_q != '0);
		sts.fits = 17'(len) <= 17'(maxp) - 17'd13;
		sts.len_one = len == 16'd1;
		sts.mode = mode_q;
		if (mode_q == hrtp_pkg::MODE_STORE)
			sts.beyond = ((hdr_q[4:0] == 5'd7) ? 16'(sps_cnt_q) : 16'(pps_cnt_q)) <= pos_q;
		else
			sts.beyond = pos_q >= len;
		sts.need_fu_hdr = fill_q == 12'd0;
		sts.nal_last = (mode_q == hrtp_pkg::MODE_FU) ?
			(pos1 >= len || fill1 >= frag) : (pos1 >= len);
		sts.cnt = cnt_q;
		sts.sps_end = 5'(cnt_q + 5'd1) >= 5'(sps_cnt_q);
		sts.pps_end = 5'(cnt_q + 5'd1) >= 5'(pps_cnt_q);
		sts.pps_zero = pps_cnt_q == '0;
	end

	always_comb begin
		obyte = hb_q;
		case (cmd.src)
			hrtp_pkg::SRC_RTP_HDR: begin
				case (cnt_q[3:0])
					4'd0: obyte = 8'h80;
					4'd1: obyte = {1'b0, ptype_q};
					4'd2: obyte = seq_q[15:8];
					4'd3: obyte = seq_q[7:0];
					4'd4: obyte = ts_q[31:24];
					4'd5: obyte = ts_q[23:16];
					4'd6: obyte = ts_q[15:8];
					4'd7: obyte = ts_q[7:0];
					4'd8: obyte = ssrc_q[31:24];
					4'd9: obyte = ssrc_q[23:16];
					4'd10: obyte = ssrc_q[15:8];
					default: obyte = ssrc_q[7:0];
				endcase
			end
			hrtp_pkg::SRC_STAP_IND: obyte = (sps_mem[0] & hrtp_pkg::NriMask) | 8'd24;
			hrtp_pkg::SRC_SPS_LEN_HI: obyte = 8'd0;
			hrtp_pkg::SRC_SPS_LEN_LO: obyte = 8'(sps_cnt_q);
			hrtp_pkg::SRC_SPS_DATA: obyte = sps_mem[ci];
			hrtp_pkg::SRC_PPS_LEN_HI: obyte = 8'd0;
			hrtp_pkg::SRC_PPS_LEN_LO: obyte = 8'(pps_cnt_q);
			hrtp_pkg::SRC_PPS_DATA: obyte = pps_mem[ci];
			hrtp_pkg::SRC_FU_IND: obyte = (hdr_q & hrtp_pkg::NriMask) | 8'd28;
			hrtp_pkg::SRC_FU_HDR: obyte = {pos_q == 16'd1, (17'(len) - 17'(pos_q)) <= 17'(frag),
				1'b0, hdr_q[4:0]};
			hrtp_pkg::SRC_NAL: obyte = hb_q;
			default: obyte = hb_q;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxp_q <= 13'd1400;
			ptype_q <= 7'd96;
			ssrc_q <= '0;
			tbase_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				2'd0: maxp_q <= cfg_data[12:0];
				2'd1: ptype_q <= cfg_data[6:0];
				2'd2: ssrc_q <= cfg_data;
				default: tbase_q <= cfg_data;
			endcase
		end
	end

	// Input hold register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load) hv_q <= 1'b1;
			else if (cmd.take) hv_q <= 1'b0;
			if (cmd.emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hb_q <= nal_byte;
			hf_q <= nal_first;
			hl_q <= nal_length;
			hms_q <= frame_time_ms;
		end
		if (cmd.emit) begin
			packet_byte <= obyte;
			packet_first <= cmd.first;
			packet_last <= cmd.last;
		end
	end

	// Unit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			sps_cnt_q <= '0;
			pps_cnt_q <= '0;
			pos_q <= '0;
			fill_q <= '0;
			mode_q <= hrtp_pkg::MODE_IDLE;
			hdr_q <= '0;
			ts_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.seq_inc) seq_q <= seq_q + 16'd1;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 5'd1;
			if (cmd.proc) begin
				if (hf_q) begin
					hdr_q <= hb_q;
					ts_q <= ts_mul;
					fill_q <= '0;
					pos_q <= 16'd1;
					if (sts.is_pset) begin
						mode_q <= hrtp_pkg::MODE_IDLE;
						if (sts.pset_ok) begin
							if (htype == 5'd7) sps_cnt_q <= CW'(len);
							else pps_cnt_q <= CW'(len);
							if (!sts.len_one) mode_q <= hrtp_pkg::MODE_STORE;
						end
					end else if (sts.fits)
						mode_q <= sts.len_one ? hrtp_pkg::MODE_IDLE : hrtp_pkg::MODE_SINGLE;
					else
						mode_q <= hrtp_pkg::MODE_FU;
				end else if (mode_q != hrtp_pkg::MODE_IDLE) begin
					if (sts.beyond) mode_q <= hrtp_pkg::MODE_IDLE;
					else begin
						pos_q <= pos1;
						if (mode_q == hrtp_pkg::MODE_STORE) begin
							if (((hdr_q[4:0] == 5'd7) ? 16'(sps_cnt_q) : 16'(pps_cnt_q)) <= pos1)
								mode_q <= hrtp_pkg::MODE_IDLE;
						end else begin
							if (mode_q == hrtp_pkg::MODE_FU)
								fill_q <= sts.nal_last ? 12'd0 : fill1;
							if (pos1 >= len) mode_q <= hrtp_pkg::MODE_IDLE;
						end
					end
				end
			end
		end
	end

	// Parameter set stores.
	always_ff @(posedge clk) begin
		if (cmd.proc) begin
			if (hf_q && sts.is_pset && sts.pset_ok) begin
				if (htype == 5'd7) sps_mem[0] <= hb_q;
				else pps_mem[0] <= hb_q;
			end else if (!hf_q && mode_q == hrtp_pkg::MODE_STORE && !sts.beyond) begin
				if (hdr_q[4:0] == 5'd7) sps_mem[pos_q[AW-1:0]] <= hb_q;
				else pps_mem[pos_q[AW-1:0]] <= hb_q;
			end
		end
	end

	assign out_valid = ov_q;

	`RTP_ASSERT_IMPL(a_no_emit_on_stall, cmd.emit, sts.out_free)
	`RTP_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid)
	`RTP_ASSERT_IMPL(a_no_load_busy, cmd.load, !hv_q || cmd.take)
	`RTP_ASSERT_IMPL(a_proc_held, cmd.proc, hv_q)
endmodule
`default_nettype wire

### rtl/core/hrtp_ctrl.sv
// Controller of the RTP packetizer: sequences header, STAP-A, FU-A and
// payload bytes. Uses hrtp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hrtp_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic nal_valid,
	input wire hrtp_pkg::sts_t sts,
	output hrtp_pkg::cmd_t cmd,
	output logic nal_stall
);
	hrtp_pkg::state_t st_q, st_d;
	logic hdr_end;

	assign hdr_end = sts.cnt == 5'(hrtp_pkg::RtpHdrBytes - 1);

	always_comb begin
		st_d = st_q;
		case (st_q)
			hrtp_pkg::ST_IDLE: begin
				if (sts.hold_v) begin
					if (sts.h_first) begin
						if (sts.is_pset) st_d = hrtp_pkg::ST_IDLE;
						else if (sts.stap_ok) st_d = hrtp_pkg::ST_STAP_HDR;
						else if (sts.fits) st_d = hrtp_pkg::ST_SNG_HDR;
					end else if (sts.mode == hrtp_pkg::MODE_FU && !sts.beyond
						&& sts.need_fu_hdr)
						st_d = hrtp_pkg::ST_FU_HDR;
					else if (sts.mode == hrtp_pkg::MODE_SINGLE && !sts.beyond
						&& sts.out_free)
						st_d = hrtp_pkg::ST_IDLE;
				end
			end
			hrtp_pkg::ST_STAP_HDR: if (sts.out_free && hdr_end) st_d = hrtp_pkg::ST_STAP_IND;
			hrtp_pkg::ST_STAP_IND: if (sts.out_free) st_d = hrtp_pkg::ST_SPS_HI;
			hrtp_pkg::ST_SPS_HI: if (sts.out_free) st_d = hrtp_pkg::ST_SPS_LO;
			hrtp_pkg::ST_SPS_LO: if (sts.out_free) st_d = hrtp_pkg::ST_SPS_DATA;
			hrtp_pkg::ST_SPS_DATA: if (sts.out_free && sts.sps_end) st_d = hrtp_pkg::ST_PPS_HI;
			hrtp_pkg::ST_PPS_HI: if (sts.out_free) st_d = hrtp_pkg::ST_PPS_LO;
			hrtp_pkg::ST_PPS_LO: if (sts.out_free) st_d = hrtp_pkg::ST_PPS_DATA;
			hrtp_pkg::ST_PPS_DATA: if (sts.out_free && sts.pps_end) begin
				st_d = sts.fits ? hrtp_pkg::ST_SNG_HDR : hrtp_pkg::ST_IDLE;
			end
			hrtp_pkg::ST_SNG_HDR: if (sts.out_free && hdr_end) st_d = hrtp_pkg::ST_NAL;
			hrtp_pkg::ST_FU_HDR: if (sts.out_free && hdr_end) st_d = hrtp_pkg::ST_FU_IND;
			hrtp_pkg::ST_FU_IND: if (sts.out_free) st_d = hrtp_pkg::ST_FU_FHDR;
			hrtp_pkg::ST_FU_FHDR: if (sts.out_free) st_d = hrtp_pkg::ST_NAL;
			hrtp_pkg::ST_NAL: if (sts.out_free) st_d = hrtp_pkg::ST_IDLE;
			default: st_d = hrtp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.src = hrtp_pkg::SRC_NAL;
		case (st_q)
			hrtp_pkg::ST_IDLE: begin
				if (sts.hold_v) begin
					if (sts.h_first) begin
						cmd.cnt_clr = 1'b1;
						// The unit timestamp is latched before any header goes out.
						cmd.proc = 1'b1;
						if (sts.is_pset || (!sts.stap_ok && !sts.fits))
							cmd.take = 1'b1;
					end else if (sts.mode == hrtp_pkg::MODE_FU && !sts.beyond) begin
						cmd.cnt_clr = 1'b1;
						if (!sts.need_fu_hdr && sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = sts.nal_last;
							cmd.proc = 1'b1;
							cmd.take = 1'b1;
						end
					end else if (sts.mode == hrtp_pkg::MODE_SINGLE && !sts.beyond) begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = sts.nal_last;
							cmd.proc = 1'b1;
							cmd.take = 1'b1;
						end
					end else begin
						cmd.proc = 1'b1;
						cmd.take = 1'b1;
					end
				end
			end
			hrtp_pkg::ST_STAP_HDR, hrtp_pkg::ST_SNG_HDR, hrtp_pkg::ST_FU_HDR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src = hrtp_pkg::SRC_RTP_HDR;
					cmd.first = sts.cnt == 5'd0;
					// The sequence number steps before its bytes are sent.
					cmd.seq_inc = sts.cnt == 5'd0;
					cmd.cnt_inc = !hdr_end;
					cmd.cnt_clr = hdr_end;
				end
			end
			hrtp_pkg::ST_STAP_IND: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_STAP_IND;
			end
			hrtp_pkg::ST_SPS_HI: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_SPS_LEN_HI;
			end
			hrtp_pkg::ST_SPS_LO: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_SPS_LEN_LO;
				cmd.cnt_clr = sts.out_free;
			end
			hrtp_pkg::ST_SPS_DATA: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src = hrtp_pkg::SRC_SPS_DATA;
					cmd.cnt_inc = !sts.sps_end;
					cmd.cnt_clr = sts.sps_end;
				end
			end
			hrtp_pkg::ST_PPS_HI: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_PPS_LEN_HI;
			end
			hrtp_pkg::ST_PPS_LO: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_PPS_LEN_LO;
				cmd.last = sts.pps_zero;
				cmd.cnt_clr = sts.out_free;
			end
			hrtp_pkg::ST_PPS_DATA: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src = hrtp_pkg::SRC_PPS_DATA;
					cmd.last = sts.pps_end;
					cmd.cnt_inc = !sts.pps_end;
					cmd.cnt_clr = sts.pps_end;
					// A unit too large for one packet only records its start here.
					if (sts.pps_end && !sts.fits) begin
						cmd.proc = 1'b1;
						cmd.take = 1'b1;
					end else if (sts.pps_end) cmd.proc = 1'b1;
				end
			end
			hrtp_pkg::ST_FU_IND: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_FU_IND;
			end
			hrtp_pkg::ST_FU_FHDR: begin
				cmd.emit = sts.out_free;
				cmd.src = hrtp_pkg::SRC_FU_HDR;
			end
			hrtp_pkg::ST_NAL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src = hrtp_pkg::SRC_NAL;
					cmd.take = 1'b1;
					if (sts.h_first) cmd.last = sts.len_one;
					else begin
						cmd.last = sts.nal_last;
						cmd.proc = 1'b1;
					end
				end
			end
			default: cmd = '0;
		endcase
		cmd.load = nal_valid && !nal_stall;
	end

	assign nal_stall = sts.hold_v && !cmd.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= hrtp_pkg::ST_IDLE;
		else st_q <= st_d;
	end
endmodule
`default_nettype wire

### rtl/core/h264_rtp_packetizer_unit.sv
// H.264 RTP packetizer (single NAL, STAP-A, FU-A): top level.
// Instances hrtp_ctrl and hrtp_datapath; uses hrtp_pkg.
// Usage:
//  Input channel nal_*: one NAL byte per request, nal_first on the header
//  byte; nal_length and frame_time_ms stay constant within a unit.
//  Output channel packet_*: one RTP packet byte per request, packet_first
//  on the first header byte, packet_last on the final byte.
//  Configuration: cfg_we with cfg_index and cfg_data, written while idle.
//  Packet opening: a byte that opens a packet first takes a decision step
//  and the 12 byte RTP header; an FU-A fragment adds its indicator and
//  header. An IDR with both parameter sets stored is preceded by a STAP-A
//  packet of 17 + SPS bytes + PPS bytes. The controller emits one byte per
//  cycle through a single output register while packet_stall is low.
//  Path: an accepted byte passes the hold register and the output register
//  before it appears as its packet byte.
//  Reset: clears sequence number, set counts and unit state; registers
//  take their defaults (1400, 96, 0, 0).
//  Stall: while packet_stall is high the output holds and the input is
//  stalled once its hold register is full.
`timescale 1ns / 1ps
`default_nettype none
module h264_rtp_packetizer_unit #(
	parameter int PARAM_SET_MAX_BYTES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic nal_valid,
	output logic nal_stall,
	input wire logic [7:0] nal_byte,
	input wire logic nal_first,
	input wire logic [15:0] nal_length,
	input wire logic [31:0] frame_time_ms,
	output logic packet_valid,
	input wire logic packet_stall,
	output logic [7:0] packet_byte,
	output logic packet_first,
	output logic packet_last
);
	hrtp_pkg::cmd_t cmd;
	hrtp_pkg::sts_t sts;

	hrtp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .nal_valid(nal_valid), .sts(sts),
		.cmd(cmd), .nal_stall(nal_stall)
	);

	hrtp_datapath #(.SetMax(PARAM_SET_MAX_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data), .nal_byte(nal_byte), .nal_first(nal_first),
		.nal_length(nal_length), .frame_time_ms(frame_time_ms),
		.out_stall(packet_stall), .cmd(cmd), .sts(sts), .out_valid(packet_valid),
		.packet_byte(packet_byte), .packet_first(packet_first),
		.packet_last(packet_last)
	);
endmodule
`default_nettype wire
